// ===== rtl/http_request_byte_parser_assert.svh =====
// Assertion macros for the request parser.
// HRBP_ASSERT checks on every clock edge outside reset.
// HRBP_ASSERT_ALWAYS also checks while reset is held.
`ifndef HTTP_REQUEST_BYTE_PARSER_ASSERT_SVH
`define HTTP_REQUEST_BYTE_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
`define HRBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
`define HRBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define HRBP_ASSERT(lbl, prop, msg)
`define HRBP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/hrbp_pkg.sv =====
package hrbp_pkg;

  // parse phases
  localparam logic [3:0] PH_START     = 4'd0;
  localparam logic [3:0] PH_METHOD    = 4'd1;
  localparam logic [3:0] PH_URI       = 4'd2;
  localparam logic [3:0] PH_VERSION   = 4'd3;
  localparam logic [3:0] PH_LINE_END  = 4'd4;
  localparam logic [3:0] PH_HDR_START = 4'd5;
  localparam logic [3:0] PH_HDR_NAME  = 4'd6;
  localparam logic [3:0] PH_HDR_VALUE = 4'd7;
  localparam logic [3:0] PH_BLANK     = 4'd8;
  localparam logic [3:0] PH_BODY      = 4'd9;
  localparam logic [3:0] PH_END       = 4'd10;

  // class of last accepted version character
  localparam logic [2:0] VC_NONE  = 3'd0;
  localparam logic [2:0] VC_H     = 3'd1;
  localparam logic [2:0] VC_T     = 3'd2;
  localparam logic [2:0] VC_P     = 3'd3;
  localparam logic [2:0] VC_SLASH = 3'd4;
  localparam logic [2:0] VC_DIGIT = 3'd5;
  localparam logic [2:0] VC_DOT   = 3'd6;

  // byte tags
  localparam logic [2:0] PART_NONE   = 3'd0;
  localparam logic [2:0] PART_METHOD = 3'd1;
  localparam logic [2:0] PART_URI    = 3'd2;
  localparam logic [2:0] PART_HNAME  = 3'd3;
  localparam logic [2:0] PART_HVALUE = 3'd4;
  localparam logic [2:0] PART_BODY   = 3'd5;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_CTL_MAX = 8'd31;

  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned OUT_USER_W = 4;

  typedef struct packed {
    logic [3:0] phase;
    logic [2:0] vlast;
    logic [3:0] major;
    logic [3:0] minor;
    logic       valid;
  } state_t;

  typedef struct packed {
    logic [2:0] part;
    logic       hbeg;
    logic       bad;
  } tag_t;

endpackage

// ===== rtl/hrbp_step.sv =====
module hrbp_step (
  input  hrbp_pkg::state_t state_i,
  input  logic [7:0]       byte_i,
  output hrbp_pkg::state_t state_o,
  output hrbp_pkg::tag_t   tag_o
);

  function automatic logic is_ctl(input logic [7:0] c);
    return (c <= hrbp_pkg::CH_CTL_MAX) || (c == hrbp_pkg::CH_DEL);
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    logic r;
    unique case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]",
      "?", "=", "{", "}", hrbp_pkg::CH_SPACE, hrbp_pkg::CH_TAB: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_token(input logic [7:0] c);
    return !c[7] && !is_ctl(c) && !is_sep(c);
  endfunction

  logic             digit;
  logic             bad;
  hrbp_pkg::state_t nxt;
  logic [2:0]       part;
  logic             hbeg;

  assign digit = (byte_i >= "0") && (byte_i <= "9");

  always_comb begin
    nxt  = state_i;
    part = hrbp_pkg::PART_NONE;
    hbeg = 1'b0;
    bad  = 1'b0;
    unique case (state_i.phase)
      hrbp_pkg::PH_START: begin
        if (!is_token(byte_i)) begin
          bad = 1'b1;
        end else begin
          part      = hrbp_pkg::PART_METHOD;
          nxt.phase = hrbp_pkg::PH_METHOD;
        end
      end
      hrbp_pkg::PH_METHOD: begin
        if (byte_i == hrbp_pkg::CH_SPACE) begin
          nxt.phase = hrbp_pkg::PH_URI;
        end else if (!is_token(byte_i)) begin
          bad = 1'b1;
        end else begin
          part = hrbp_pkg::PART_METHOD;
        end
      end
      hrbp_pkg::PH_URI: begin
        if (is_ctl(byte_i)) begin
          bad = 1'b1;
        end else if (byte_i == hrbp_pkg::CH_SPACE) begin
          nxt.phase = hrbp_pkg::PH_VERSION;
        end else begin
          part = hrbp_pkg::PART_URI;
        end
      end
      hrbp_pkg::PH_VERSION: begin
        priority if (byte_i == "H" && state_i.vlast == hrbp_pkg::VC_NONE) begin
          nxt.vlast = hrbp_pkg::VC_H;
        end else if (state_i.vlast == hrbp_pkg::VC_NONE) begin
          bad = 1'b1;
        end else if (byte_i == "T" && (state_i.vlast == hrbp_pkg::VC_H ||
                                       state_i.vlast == hrbp_pkg::VC_T)) begin
          nxt.vlast = hrbp_pkg::VC_T;
        end else if (byte_i == "P" && state_i.vlast == hrbp_pkg::VC_T) begin
          nxt.vlast = hrbp_pkg::VC_P;
        end else if (byte_i == "/" && state_i.vlast == hrbp_pkg::VC_P) begin
          nxt.vlast = hrbp_pkg::VC_SLASH;
        end else if (digit && state_i.vlast == hrbp_pkg::VC_SLASH) begin
          nxt.vlast = hrbp_pkg::VC_DIGIT;
          nxt.major = byte_i[3:0];  // ASCII digits carry their value in the low nibble
        end else if (byte_i == "." && state_i.vlast == hrbp_pkg::VC_DIGIT) begin
          nxt.vlast = hrbp_pkg::VC_DOT;
        end else if (digit && state_i.vlast == hrbp_pkg::VC_DOT) begin
          nxt.vlast = hrbp_pkg::VC_DIGIT;
          nxt.minor = byte_i[3:0];
        end else if (byte_i == hrbp_pkg::CH_CR && state_i.vlast == hrbp_pkg::VC_DIGIT) begin
          nxt.phase = hrbp_pkg::PH_LINE_END;
        end else begin
          bad = 1'b1;
        end
      end
      hrbp_pkg::PH_LINE_END: begin
        if (byte_i != hrbp_pkg::CH_LF) begin
          bad = 1'b1;
        end else begin
          nxt.phase = hrbp_pkg::PH_HDR_START;
        end
      end
      hrbp_pkg::PH_HDR_START: begin
        if (byte_i == hrbp_pkg::CH_CR) begin
          nxt.phase = hrbp_pkg::PH_BLANK;
        end else begin
          part      = hrbp_pkg::PART_HNAME;
          hbeg      = 1'b1;
          nxt.phase = hrbp_pkg::PH_HDR_NAME;
        end
      end
      hrbp_pkg::PH_HDR_NAME: begin
        if (byte_i == hrbp_pkg::CH_COLON) begin
          nxt.phase = hrbp_pkg::PH_HDR_VALUE;
        end else begin
          part = hrbp_pkg::PART_HNAME;
        end
      end
      hrbp_pkg::PH_HDR_VALUE: begin
        if (byte_i == hrbp_pkg::CH_CR) begin
          nxt.phase = hrbp_pkg::PH_LINE_END;
        end else if (byte_i != hrbp_pkg::CH_SPACE) begin
          part = hrbp_pkg::PART_HVALUE;
        end
      end
      hrbp_pkg::PH_BLANK: begin
        if (byte_i != hrbp_pkg::CH_LF) begin
          bad = 1'b1;
        end else begin
          nxt.valid = 1'b1;
          nxt.phase = hrbp_pkg::PH_BODY;
        end
      end
      hrbp_pkg::PH_BODY: begin
        if (byte_i == hrbp_pkg::CH_CR) begin
          nxt.phase = hrbp_pkg::PH_END;
        end else begin
          nxt.valid = 1'b0;
          part      = hrbp_pkg::PART_BODY;
        end
      end
      hrbp_pkg::PH_END: begin
        if (byte_i != hrbp_pkg::CH_LF) begin
          bad = 1'b1;
        end else begin
          nxt.valid = 1'b1;
        end
      end
      default: bad = 1'b1;  // unreachable phase codes
    endcase
  end

  // an error leaves the whole state untouched, clears the tag's part and header-begin fields and sets its bad flag
  always_comb begin
    state_o    = bad ? state_i : nxt;
    tag_o.part = bad ? hrbp_pkg::PART_NONE : part;
    tag_o.hbeg = bad ? 1'b0 : hbeg;
    tag_o.bad  = bad;
  end

endmodule

// ===== rtl/http_request_byte_parser.sv =====
// Path: an accepted item passes through the input register, then the result register,
// and waits there while the output is stalled.
// Throughput: one item per cycle while the output is not stalled; the phase update for one
// byte fits between the input register and the result register.
// Reset: asynchronous, active low; clears the parse state to the start phase with
// no version data and both stages empty.
`include "http_request_byte_parser_assert.svh"

module http_request_byte_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] byte_out, [8] bad_req, [9] request_valid, [13:10] phase_out,
  // [17:14] major_version, [21:18] minor_version, [23:22] zero
  output logic [hrbp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [2:0] part, [3] header_begin
  output logic [hrbp_pkg::OUT_USER_W-1:0] m_axis_tuser
);

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             out_valid_q;
  logic [hrbp_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic [hrbp_pkg::OUT_USER_W-1:0] out_user_q, out_user_d;
  hrbp_pkg::state_t state_q, state_d;
  hrbp_pkg::tag_t   tag;
  logic             out_free;
  logic             adv;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  hrbp_step u_step (
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .state_o (state_d),
    .tag_o   (tag)
  );

  assign out_data_d = {2'b00, state_d.minor, state_d.major, state_d.phase,
                       state_d.valid, tag.bad, in_byte_q};
  assign out_user_d = {tag.hbeg, tag.part};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      state_q     <= '{phase: hrbp_pkg::PH_START, vlast: hrbp_pkg::VC_NONE,
                       major: 4'd0, minor: 4'd0, valid: 1'b0};
    end else if (adv) begin
      out_valid_q <= 1'b1;
      state_q     <= state_d;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // the shown phase is always the live state, since both load on the same edge
  `HRBP_ASSERT(a_phase_tracks, out_valid_q |-> (out_data_q[13:10] == state_q.phase), "phase")
  `HRBP_ASSERT(a_bad_no_tag, (out_valid_q && out_data_q[8]) |-> (out_user_q == '0), "tag")
  `HRBP_ASSERT(a_hbeg_phase, (out_valid_q && out_user_q[3]) |-> state_q.phase == hrbp_pkg::PH_HDR_NAME, "hbeg")
  `HRBP_ASSERT(a_bad_holds, (adv && tag.bad) |=> $stable(state_q), "state moved on error")
  `HRBP_ASSERT(a_idle_holds, !adv |=> $stable(state_q), "state moved without item")
  `HRBP_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (!out_valid_q && !in_valid_q), "not empty in reset")

endmodule
